// ----- rtl/mbps_pkg.sv -----
// mbps_pkg: shared types, constants and helpers for the masked byte pattern search
// used by every module of the block and by its checker
// no dependencies
package mbps_pkg;

  localparam int MAX_PATTERN_LEN_DEF = 16;
  localparam int ADDR_WIDTH          = 32;
  localparam int SIG_BYTES           = 16;
  localparam int CFG_DATA_W          = 64;
  localparam int CFG_IDX_W           = 3;

  // address arithmetic wraps at ADDR_WIDTH bits, then is cut to 32
  localparam logic [31:0] ADDR_MASK =
    (ADDR_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  localparam logic [15:0] CARE_RESET = 16'hFFFF;
  localparam logic [4:0]  LEN_RESET  = 5'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAT_LO = 3'd0,
    CFG_PAT_HI = 3'd1,
    CFG_CARE   = 3'd2,
    CFG_LEN    = 3'd3,
    CFG_BASE   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        found;
    logic [31:0] match_address;
  } out_word_t;

  typedef struct packed {
    logic      valid;
    out_word_t word;
  } scan_res_t;

  // byte idx of the 16-byte signature
  function automatic logic [7:0] sig_byte(input logic [8*SIG_BYTES-1:0] pat,
                                          input logic [3:0] idx);
    sig_byte = pat[idx*8 +: 8];
  endfunction

endpackage

// ----- rtl/mbps_scan.sv -----
// mbps_scan: config registers, byte window, bytes-seen count and the parallel compare
// produces at most one result per accepted word; depends on mbps_pkg
module mbps_scan import mbps_pkg::*; #(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  in_word_t              in_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output scan_res_t             res
);

  localparam int LEN_CLOG = $clog2(MAX_PATTERN_LEN + 1);
  localparam int LEN_W    = (LEN_CLOG > 5) ? LEN_CLOG : 5;

  logic [63:0] pat_lo_r;
  logic [63:0] pat_hi_r;
  logic [15:0] care_r;
  logic [4:0]  plen_r;
  logic [31:0] base_r;

  logic [7:0]  win_r   [MAX_PATTERN_LEN];
  logic [7:0]  win_nxt [MAX_PATTERN_LEN];
  logic [31:0] seen_r;
  logic        done_r;

  logic [31:0]          seen_nxt;
  logic                 all_wild;
  logic [LEN_W-1:0]     len_c;
  logic [MAX_PATTERN_LEN-1:0] care_al;
  logic [MAX_PATTERN_LEN-1:0] pos_ok;
  logic                 seen_ok;
  logic                 hit;
  logic [31:0]          offset;
  logic [31:0]          addr;

  assign seen_nxt = seen_r + 32'd1;
  assign all_wild = (plen_r == 5'd0);

  always_comb begin
    if (all_wild) begin
      len_c = LEN_W'(1);
    end else if (LEN_W'(plen_r) > LEN_W'(MAX_PATTERN_LEN)) begin
      len_c = LEN_W'(MAX_PATTERN_LEN);
    end else begin
      len_c = LEN_W'(plen_r);
    end
  end

  // new window: incoming byte at entry 0, older bytes move up
  always_comb begin
    win_nxt[0] = in_data.data_byte;
    for (int w = 1; w < MAX_PATTERN_LEN; w++) begin
      win_nxt[w] = win_r[w-1];
    end
  end

  // signature aligned to window entries: entry w faces signature position len-1-w
  always_comb begin
    logic [LEN_W-1:0] pos;
    logic             in_use;
    for (int w = 0; w < MAX_PATTERN_LEN; w++) begin
      in_use     = LEN_W'(w) < len_c;
      pos        = len_c - LEN_W'(1) - LEN_W'(w);
      care_al[w] = in_use && !all_wild && (pos < LEN_W'(SIG_BYTES)) && care_r[pos[3:0]];
      pos_ok[w]  = !care_al[w] || (win_nxt[w] == sig_byte({pat_hi_r, pat_lo_r}, pos[3:0]));
    end
  end

  assign seen_ok = seen_nxt >= 32'(len_c);
  assign hit     = seen_ok && (&pos_ok);
  assign offset  = seen_nxt - 32'(len_c);
  assign addr    = (base_r + offset) & ADDR_MASK;

  always_comb begin
    res.valid              = accept && !done_r && (hit || in_data.last_byte);
    res.word.found         = hit;
    res.word.match_address = hit ? addr : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_lo_r <= '0;
      pat_hi_r <= '0;
      care_r   <= CARE_RESET;
      plen_r   <= LEN_RESET;
      base_r   <= '0;
      seen_r   <= '0;
      done_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PAT_LO: pat_lo_r <= cfg_wdata;
          CFG_PAT_HI: pat_hi_r <= cfg_wdata;
          CFG_CARE:   care_r   <= cfg_wdata[15:0];
          CFG_LEN:    plen_r   <= cfg_wdata[4:0];
          CFG_BASE:   base_r   <= cfg_wdata[31:0];
          default:    ;
        endcase
      end
      if (accept) begin
        if (done_r) begin
          if (in_data.last_byte) begin
            seen_r <= '0;
            done_r <= 1'b0;
          end
        end else if (in_data.last_byte) begin
          seen_r <= '0;
          done_r <= 1'b0;
        end else begin
          seen_r <= seen_nxt;
          done_r <= hit;
        end
      end
    end
  end

  // window is payload; stale entries are never compared since seen_r gates the test
  always_ff @(posedge clk) begin
    if (accept && !done_r) begin
      for (int w = 0; w < MAX_PATTERN_LEN; w++) begin
        win_r[w] <= win_nxt[w];
      end
    end
  end

endmodule

// ----- rtl/mbps_out_buf.sv -----
// mbps_out_buf: output register plus one skid entry for result words
// stall toward the input rises only when the skid entry is full; depends on mbps_pkg
module mbps_out_buf import mbps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_res_t push,
  output logic      full,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic      main_vld_r;
  logic      skid_vld_r;
  out_word_t main_r;
  out_word_t skid_r;
  logic      pop;

  assign pop       = main_vld_r && !out_stall;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;
  assign full      = skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        main_r     <= skid_r;
        skid_vld_r <= 1'b0;
      end else if (push.valid) begin
        main_r <= push.word;
      end else begin
        main_vld_r <= 1'b0;
      end
    end else if (push.valid) begin
      if (!main_vld_r) begin
        main_r     <= push.word;
        main_vld_r <= 1'b1;
      end else begin
        skid_r     <= push.word;
        skid_vld_r <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/masked_byte_pattern_search.sv -----
// masked_byte_pattern_search: top level, scan core feeding a skid-buffered result register
// depends on mbps_pkg, mbps_scan, mbps_out_buf
//
//  channel | ports                               | moves
//  --------+-------------------------------------+------------------------------------
//  in      | in_valid, in_stall, in_data         | one region byte and end flag a word
//  out     | out_valid, out_stall, out_data      | found flag and match address
//  cfg     | cfg_we, cfg_index, cfg_wdata        | register writes, no read-back
//
// one byte is accepted every cycle while in_stall is low; the window compare and address add
// sit between the window registers and the result register, so each result is registered
// in_stall rises only when both the result register and the skid entry hold words
// synchronous reset clears the count, the match flag and both result entries and loads
// the register reset values; the window bytes are not cleared
module masked_byte_pattern_search import mbps_pkg::*; #(
  parameter int MAX_PATTERN_LEN = MAX_PATTERN_LEN_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic      accept;
  logic      buf_full;
  scan_res_t res;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  mbps_scan #(
    .MAX_PATTERN_LEN (MAX_PATTERN_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .res       (res)
  );

  mbps_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/mbps_checker.sv -----
// mbps_checker: port-level assertions for masked_byte_pattern_search
// bound to the top level below; depends on mbps_pkg
module mbps_checker import mbps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // no-match report carries a zero address
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.match_address == 32'd0)
    else $error("no-match result with nonzero address");

  // a fresh result needs a word taken the cycle before
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result without an accepted word");

  // reset empties the result side
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("result side not empty after reset");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (.*);
